// ===== rtl/core/teo_pkg.sv =====
// Shared constants, payload types and status codes for the triangle edge offset block.
`timescale 1ns / 1ps
`default_nettype none

package teo_pkg;

    // Coordinate format and unit-vector precision.
    localparam int COORD_W   = 32;
    localparam int UNIT_BITS = 30;

    // Unit-direction datapath widths.
    localparam int DELTA_W  = COORD_W + 1;
    localparam int KMAX     = DELTA_W - UNIT_BITS;
    localparam int KW       = $clog2(KMAX + 1);
    localparam int SQ_IN_W  = 2 * UNIT_BITS + 1;
    localparam int SQ_W     = SQ_IN_W + 1;
    localparam int SQ_ITER  = UNIT_BITS + 1;
    localparam int LEN_W    = UNIT_BITS + 1;
    localparam int UQ_W     = UNIT_BITS + 1;
    localparam int DN_W     = 2 * UNIT_BITS + 1;
    localparam int U_W      = UNIT_BITS + 2;

    // Corner datapath widths.
    localparam int CR_W     = 2 * U_W;
    localparam int DV_W     = CR_W - 1;
    localparam int E_W      = U_W + 1;
    localparam int PROD_W   = COORD_W + E_W;
    localparam int N_W      = PROD_W + UNIT_BITS;
    localparam int Q_W      = COORD_W + 1;
    localparam int V_W      = COORD_W + 3;

    // Pipeline depths.
    localparam int UNIT_LAT     = 5 + SQ_ITER + 1 + UQ_W + 1;
    localparam int CORNER_FRONT = 6;
    localparam int CORNER_LAT   = CORNER_FRONT + Q_W + 1;
    localparam int PIPE_N       = UNIT_LAT + CORNER_LAT;

    // Status codes.
    localparam logic [1:0] STAT_OK  = 2'd0;
    localparam logic [1:0] STAT_PAR = 2'd1;
    localparam logic [1:0] STAT_SAT = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex0_x;
        logic signed [COORD_W-1:0] vertex0_y;
        logic signed [COORD_W-1:0] vertex1_x;
        logic signed [COORD_W-1:0] vertex1_y;
        logic signed [COORD_W-1:0] vertex2_x;
        logic signed [COORD_W-1:0] vertex2_y;
        logic signed [COORD_W-1:0] offset_distance;
    } t_teo_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] corner0_x;
        logic signed [COORD_W-1:0] corner0_y;
        logic signed [COORD_W-1:0] corner1_x;
        logic signed [COORD_W-1:0] corner1_y;
        logic signed [COORD_W-1:0] corner2_x;
        logic signed [COORD_W-1:0] corner2_y;
        logic [1:0]                status;
    } t_teo_out;

    typedef struct packed {
        logic par;
        logic sat;
    } t_teo_flag;

endpackage

`default_nettype wire

// ===== rtl/core/teo_if.sv =====
// Valid/ready channel interfaces for the triangle input and the corner result.
`timescale 1ns / 1ps
`default_nettype none

interface teo_in_if import teo_pkg::*; ();
    logic    valid;
    logic    ready;
    t_teo_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface teo_out_if import teo_pkg::*; ();
    logic     valid;
    logic     ready;
    t_teo_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/teo_unit.sv =====
// Pipelined unit-direction unit: edge delta, scaling, square root and two divisions.
`timescale 1ns / 1ps
`default_nettype none

module teo_unit import teo_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [COORD_W-1:0] i_bx,
    input  logic signed [COORD_W-1:0] i_by,
    input  logic signed [COORD_W-1:0] i_ex,
    input  logic signed [COORD_W-1:0] i_ey,
    output logic signed [U_W-1:0]     o_ux,
    output logic signed [U_W-1:0]     o_uy
);

    typedef struct packed {
        logic [UNIT_BITS-1:0] a;
        logic [UNIT_BITS-1:0] b;
        logic                 sx;
        logic                 sy;
    } t_ucar;

    typedef struct packed {
        logic [DN_W-1:0]  na;
        logic [DN_W-1:0]  nb;
        logic [LEN_W-1:0] len;
        logic             zero;
        logic             sx;
        logic             sy;
        logic [LEN_W-1:0] ra;
        logic [LEN_W-1:0] rb;
        logic [UQ_W-1:0]  qa;
        logic [UQ_W-1:0]  qb;
    } t_udiv;

    logic [DELTA_W-1:0]     r_dx, r_dy;
    logic [DELTA_W-1:0]     r_ma, r_mb;
    logic                   r_sx2, r_sy2;
    logic [DELTA_W-1:0]     w_m;
    logic [KW-1:0]          n_k;
    t_ucar                  r_c3, r_c4, r_c5;
    logic [2*UNIT_BITS-1:0] r_aa, r_bb;
    logic [SQ_IN_W-1:0]     r_x;
    logic [SQ_W-1:0]        r_sqx [SQ_ITER];
    logic [SQ_W-1:0]        r_sqr [SQ_ITER];
    t_ucar                  r_sqc [SQ_ITER];
    t_udiv                  r_dp;
    t_udiv                  r_dv  [UQ_W];
    logic [LEN_W-1:0]       w_len;

    // Edge delta, kept exact in one extra bit.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx <= {i_ex[COORD_W-1], i_ex} - {i_bx[COORD_W-1], i_bx};
            r_dy <= {i_ey[COORD_W-1], i_ey} - {i_by[COORD_W-1], i_by};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma  <= r_dx[DELTA_W-1] ? (-r_dx) : r_dx;
            r_mb  <= r_dy[DELTA_W-1] ? (-r_dy) : r_dy;
            r_sx2 <= r_dx[DELTA_W-1];
            r_sy2 <= r_dy[DELTA_W-1];
        end
    end

    // Smallest right shift that brings the larger magnitude below 2^UNIT_BITS.
    assign w_m = (r_ma > r_mb) ? r_ma : r_mb;

    always_comb begin
        n_k = KW'(KMAX);
        for (int j = KMAX; j >= 0; j--) begin
            if (((w_m >> j) >> UNIT_BITS) == DELTA_W'(0)) begin
                n_k = KW'(j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c3.a  <= UNIT_BITS'(r_ma >> n_k);
            r_c3.b  <= UNIT_BITS'(r_mb >> n_k);
            r_c3.sx <= r_sx2;
            r_c3.sy <= r_sy2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_aa <= r_c3.a * r_c3.a;
            r_bb <= r_c3.b * r_c3.b;
            r_c4 <= r_c3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x  <= SQ_IN_W'(r_aa) + SQ_IN_W'(r_bb);
            r_c5 <= r_c4;
        end
    end

    // Digit-by-digit integer square root, one result bit per stage.
    for (genvar g = 0; g < SQ_ITER; g++) begin : g_sq
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_ITER - 1 - g));
        logic [SQ_W-1:0] x_in, r_in, trial;
        t_ucar           c_in;
        if (g == 0) begin : g_first
            assign x_in = SQ_W'(r_x);
            assign r_in = '0;
            assign c_in = r_c5;
        end else begin : g_next
            assign x_in = r_sqx[g-1];
            assign r_in = r_sqr[g-1];
            assign c_in = r_sqc[g-1];
        end
        assign trial = r_in + BIT;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (x_in >= trial) begin
                    r_sqx[g] <= x_in - trial;
                    r_sqr[g] <= (r_in >> 1) + BIT;
                end else begin
                    r_sqx[g] <= x_in;
                    r_sqr[g] <= r_in >> 1;
                end
                r_sqc[g] <= c_in;
            end
        end
    end

    assign w_len = LEN_W'(r_sqr[SQ_ITER-1]);

    // Rounded numerators; the high part is already below the length.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dp.na   <= (DN_W'(r_sqc[SQ_ITER-1].a) << UNIT_BITS) + DN_W'(w_len >> 1);
            r_dp.nb   <= (DN_W'(r_sqc[SQ_ITER-1].b) << UNIT_BITS) + DN_W'(w_len >> 1);
            r_dp.len  <= w_len;
            r_dp.zero <= (w_len == '0);
            r_dp.sx   <= r_sqc[SQ_ITER-1].sx;
            r_dp.sy   <= r_sqc[SQ_ITER-1].sy;
            r_dp.ra   <= LEN_W'(((DN_W'(r_sqc[SQ_ITER-1].a) << UNIT_BITS)
                          + DN_W'(w_len >> 1)) >> UQ_W);
            r_dp.rb   <= LEN_W'(((DN_W'(r_sqc[SQ_ITER-1].b) << UNIT_BITS)
                          + DN_W'(w_len >> 1)) >> UQ_W);
            r_dp.qa   <= '0;
            r_dp.qb   <= '0;
        end
    end

    // Restoring division, one quotient bit per stage for both components.
    for (genvar g = 0; g < UQ_W; g++) begin : g_dv
        localparam logic [UQ_W-1:0] QBIT = UQ_W'(1) << (UQ_W - 1 - g);
        t_udiv          d_in;
        t_udiv          n_dv;
        logic [LEN_W:0] ta, tb, dl;
        if (g == 0) begin : g_first
            assign d_in = r_dp;
        end else begin : g_next
            assign d_in = r_dv[g-1];
        end
        assign ta = {d_in.ra, d_in.na[UQ_W-1-g]};
        assign tb = {d_in.rb, d_in.nb[UQ_W-1-g]};
        assign dl = {1'b0, d_in.len};
        always_comb begin
            n_dv = d_in;
            if (ta >= dl) begin
                n_dv.ra = LEN_W'(ta - dl);
                n_dv.qa = d_in.qa | QBIT;
            end else begin
                n_dv.ra = LEN_W'(ta);
            end
            if (tb >= dl) begin
                n_dv.rb = LEN_W'(tb - dl);
                n_dv.qb = d_in.qb | QBIT;
            end else begin
                n_dv.rb = LEN_W'(tb);
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[g] <= n_dv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_dv[UQ_W-1].zero) begin
                o_ux <= '0;
                o_uy <= '0;
            end else begin
                o_ux <= r_dv[UQ_W-1].sx ? -$signed(U_W'(r_dv[UQ_W-1].qa))
                                        : $signed(U_W'(r_dv[UQ_W-1].qa));
                o_uy <= r_dv[UQ_W-1].sy ? -$signed(U_W'(r_dv[UQ_W-1].qb))
                                        : $signed(U_W'(r_dv[UQ_W-1].qb));
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/teo_corner.sv =====
// Pipelined corner unit: cross product, scaled offset division and saturation.
`timescale 1ns / 1ps
`default_nettype none

module teo_corner import teo_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [U_W-1:0]     i_u1x,
    input  logic signed [U_W-1:0]     i_u1y,
    input  logic signed [U_W-1:0]     i_u2x,
    input  logic signed [U_W-1:0]     i_u2y,
    input  logic signed [COORD_W-1:0] i_s,
    input  logic signed [COORD_W-1:0] i_px,
    input  logic signed [COORD_W-1:0] i_py,
    output logic signed [COORD_W-1:0] o_cx,
    output logic signed [COORD_W-1:0] o_cy,
    output t_teo_flag                 o_flag
);

    typedef struct packed {
        logic [Q_W-1:0]  lo;
        logic [DV_W-1:0] rem;
        logic [Q_W-1:0]  q;
        logic            big;
        logic            neg;
    } t_cax;

    typedef struct packed {
        t_cax            x;
        t_cax            y;
        logic [DV_W-1:0] dv;
        logic            par;
    } t_cst;

    logic signed [COORD_W-1:0] r_fpx [CORNER_LAT-1];
    logic signed [COORD_W-1:0] r_fpy [CORNER_LAT-1];

    logic signed [CR_W-1:0]    r1_p1, r1_p2, r2_cr;
    logic signed [E_W-1:0]     r1_ex, r1_ey, r2_ex, r2_ey;
    logic signed [COORD_W-1:0] r1_s, r2_s;
    logic [DV_W-1:0]           r3_dv, r4_dv, r5_dv;
    logic                      r3_par, r4_par, r5_par;
    logic [COORD_W-1:0]        r3_ms;
    logic [E_W-1:0]            r3_nex, r3_ney;
    logic                      r3_nx, r3_ny, r4_nx, r4_ny, r5_nx, r5_ny;
    logic [PROD_W-1:0]         r4_prx, r4_pry;
    logic [N_W-1:0]            r5_numx, r5_numy;
    logic [N_W-Q_W-1:0]        w_hx, w_hy;
    logic                      w_bigx, w_bigy;
    t_cst                      r6;
    t_cst                      r_dv [Q_W];

    // The vertex rides along the whole pipe.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fpx[0] <= i_px;
            r_fpy[0] <= i_py;
            for (int j = 1; j < CORNER_LAT - 1; j++) begin
                r_fpx[j] <= r_fpx[j-1];
                r_fpy[j] <= r_fpy[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p1 <= i_u1x * i_u2y;
            r1_p2 <= i_u1y * i_u2x;
            r1_ex <= E_W'(i_u1x) - E_W'(i_u2x);
            r1_ey <= E_W'(i_u1y) - E_W'(i_u2y);
            r1_s  <= i_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_cr <= r1_p1 - r1_p2;
            r2_ex <= r1_ex;
            r2_ey <= r1_ey;
            r2_s  <= r1_s;
        end
    end

    // Magnitudes and result signs.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_dv  <= DV_W'(r2_cr[CR_W-1] ? -r2_cr : r2_cr);
            r3_par <= (r2_cr == '0);
            r3_ms  <= r2_s[COORD_W-1] ? COORD_W'(-r2_s) : COORD_W'(r2_s);
            r3_nex <= r2_ex[E_W-1] ? E_W'(-r2_ex) : E_W'(r2_ex);
            r3_ney <= r2_ey[E_W-1] ? E_W'(-r2_ey) : E_W'(r2_ey);
            r3_nx  <= r2_s[COORD_W-1] ^ r2_ex[E_W-1] ^ r2_cr[CR_W-1];
            r3_ny  <= r2_s[COORD_W-1] ^ r2_ey[E_W-1] ^ r2_cr[CR_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_prx <= PROD_W'(r3_ms) * PROD_W'(r3_nex);
            r4_pry <= PROD_W'(r3_ms) * PROD_W'(r3_ney);
            r4_dv  <= r3_dv;
            r4_par <= r3_par;
            r4_nx  <= r3_nx;
            r4_ny  <= r3_ny;
        end
    end

    // Scale up by the unit precision and add half the divisor for rounding.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_numx <= (N_W'(r4_prx) << UNIT_BITS) + N_W'(r4_dv >> 1);
            r5_numy <= (N_W'(r4_pry) << UNIT_BITS) + N_W'(r4_dv >> 1);
            r5_dv   <= r4_dv;
            r5_par  <= r4_par;
            r5_nx   <= r4_nx;
            r5_ny   <= r4_ny;
        end
    end

    // A quotient that needs more than Q_W bits saturates any corner anyway.
    assign w_hx   = r5_numx[N_W-1:Q_W];
    assign w_hy   = r5_numy[N_W-1:Q_W];
    assign w_bigx = (DV_W'(w_hx) >= r5_dv);
    assign w_bigy = (DV_W'(w_hy) >= r5_dv);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6.x.lo  <= r5_numx[Q_W-1:0];
            r6.x.rem <= w_bigx ? '0 : DV_W'(w_hx);
            r6.x.q   <= '0;
            r6.x.big <= w_bigx;
            r6.x.neg <= r5_nx;
            r6.y.lo  <= r5_numy[Q_W-1:0];
            r6.y.rem <= w_bigy ? '0 : DV_W'(w_hy);
            r6.y.q   <= '0;
            r6.y.big <= w_bigy;
            r6.y.neg <= r5_ny;
            r6.dv    <= r5_dv;
            r6.par   <= r5_par;
        end
    end

    for (genvar g = 0; g < Q_W; g++) begin : g_dv
        localparam logic [Q_W-1:0] QBIT = Q_W'(1) << (Q_W - 1 - g);
        t_cst          d_in;
        t_cst          n_dv;
        logic [DV_W:0] tx, ty, dd;
        if (g == 0) begin : g_first
            assign d_in = r6;
        end else begin : g_next
            assign d_in = r_dv[g-1];
        end
        assign tx = {d_in.x.rem, d_in.x.lo[Q_W-1-g]};
        assign ty = {d_in.y.rem, d_in.y.lo[Q_W-1-g]};
        assign dd = {1'b0, d_in.dv};
        always_comb begin
            n_dv = d_in;
            if (tx >= dd) begin
                n_dv.x.rem = DV_W'(tx - dd);
                n_dv.x.q   = d_in.x.q | QBIT;
            end else begin
                n_dv.x.rem = DV_W'(tx);
            end
            if (ty >= dd) begin
                n_dv.y.rem = DV_W'(ty - dd);
                n_dv.y.q   = d_in.y.q | QBIT;
            end else begin
                n_dv.y.rem = DV_W'(ty);
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[g] <= n_dv;
            end
        end
    end

    // Apply the sign, add to the vertex and clamp to the coordinate range.
    logic signed [V_W-1:0]     w_offx, w_offy, w_vx, w_vy;
    logic                      w_fitx, w_fity, w_negx, w_negy;
    logic signed [COORD_W-1:0] w_cx, w_cy;
    t_cst                      w_l;

    assign w_l    = r_dv[Q_W-1];
    assign w_offx = w_l.x.neg ? -$signed(V_W'(w_l.x.q)) : $signed(V_W'(w_l.x.q));
    assign w_offy = w_l.y.neg ? -$signed(V_W'(w_l.y.q)) : $signed(V_W'(w_l.y.q));
    assign w_vx   = V_W'(r_fpx[CORNER_LAT-2]) + w_offx;
    assign w_vy   = V_W'(r_fpy[CORNER_LAT-2]) + w_offy;
    assign w_fitx = (&w_vx[V_W-1:COORD_W-1]) || !(|w_vx[V_W-1:COORD_W-1]);
    assign w_fity = (&w_vy[V_W-1:COORD_W-1]) || !(|w_vy[V_W-1:COORD_W-1]);
    assign w_negx = w_l.x.big ? w_l.x.neg : w_vx[V_W-1];
    assign w_negy = w_l.y.big ? w_l.y.neg : w_vy[V_W-1];

    always_comb begin
        if (w_l.x.big || !w_fitx) begin
            w_cx = w_negx ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
            w_cx = w_vx[COORD_W-1:0];
        end
        if (w_l.y.big || !w_fity) begin
            w_cy = w_negy ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
            w_cy = w_vy[COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_l.par) begin
                o_cx       <= r_fpx[CORNER_LAT-2];
                o_cy       <= r_fpy[CORNER_LAT-2];
                o_flag.par <= 1'b1;
                o_flag.sat <= 1'b0;
            end else begin
                o_cx       <= w_cx;
                o_cy       <= w_cy;
                o_flag.par <= 1'b0;
                o_flag.sat <= w_l.x.big || !w_fitx || w_l.y.big || !w_fity;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/triangle_edge_offset_top.sv =====
// Top level of the triangle edge offset block: handshake, pipeline control and output.
//
// Use: a triangle (three Q16.16 vertices) and an offset distance arrive as one
// item on i_in. Every edge is moved sideways by the distance along its
// right-hand normal, and adjacent moved edges are intersected. One result item
// leaves on o_out with the three new corners and a status code: ok, parallel
// adjacent edges (that corner keeps its vertex), or saturated.
// Throughput is one item per clock cycle while results are taken. The depth
// of the pipe comes from the square root and the two restoring divisions,
// each resolved one bit per pipeline stage.
// The pipe advances as a whole: whenever the output register is empty or being
// taken. While the receiver stalls a held result, every stage holds and i_in
// is not ready, so no item is lost or repeated.
// Reset (i_rst_n low, synchronous) clears every valid bit; the data registers
// are not reset, and the block has no configuration.
`timescale 1ns / 1ps
`default_nettype none

module triangle_edge_offset_top import teo_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    teo_in_if.sink    i_in,
    teo_out_if.source o_out
);

    logic                      w_adv;
    logic [PIPE_N-1:0]         r_vld;
    t_teo_in                   r_dl [UNIT_LAT];
    logic                      r_out_vld;
    t_teo_out                  r_out;
    logic signed [U_W-1:0]     w_ux [3];
    logic signed [U_W-1:0]     w_uy [3];
    logic signed [COORD_W-1:0] w_cx [3];
    logic signed [COORD_W-1:0] w_cy [3];
    t_teo_flag                 w_fl [3];
    logic signed [COORD_W-1:0] w_px [3];
    logic signed [COORD_W-1:0] w_py [3];

    // The whole pipe moves when the output slot is free or being emptied.
    assign w_adv       = !r_out_vld || o_out.ready;
    assign i_in.ready  = w_adv;
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld     <= {r_vld[PIPE_N-2:0], i_in.valid};
            r_out_vld <= r_vld[PIPE_N-1];
        end
    end

    // Vertices and distance wait here until the unit directions are ready.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dl[0] <= i_in.data;
            for (int j = 1; j < UNIT_LAT; j++) begin
                r_dl[j] <= r_dl[j-1];
            end
        end
    end

    // Edge 0 runs p0->p1, edge 1 p1->p2, edge 2 p2->p0.
    teo_unit u_unit0 (
        .i_clk (i_clk), .i_en (w_adv),
        .i_bx (i_in.data.vertex0_x), .i_by (i_in.data.vertex0_y),
        .i_ex (i_in.data.vertex1_x), .i_ey (i_in.data.vertex1_y),
        .o_ux (w_ux[0]), .o_uy (w_uy[0])
    );

    teo_unit u_unit1 (
        .i_clk (i_clk), .i_en (w_adv),
        .i_bx (i_in.data.vertex1_x), .i_by (i_in.data.vertex1_y),
        .i_ex (i_in.data.vertex2_x), .i_ey (i_in.data.vertex2_y),
        .o_ux (w_ux[1]), .o_uy (w_uy[1])
    );

    teo_unit u_unit2 (
        .i_clk (i_clk), .i_en (w_adv),
        .i_bx (i_in.data.vertex2_x), .i_by (i_in.data.vertex2_y),
        .i_ex (i_in.data.vertex0_x), .i_ey (i_in.data.vertex0_y),
        .o_ux (w_ux[2]), .o_uy (w_uy[2])
    );

    assign w_px[0] = r_dl[UNIT_LAT-1].vertex0_x;
    assign w_py[0] = r_dl[UNIT_LAT-1].vertex0_y;
    assign w_px[1] = r_dl[UNIT_LAT-1].vertex1_x;
    assign w_py[1] = r_dl[UNIT_LAT-1].vertex1_y;
    assign w_px[2] = r_dl[UNIT_LAT-1].vertex2_x;
    assign w_py[2] = r_dl[UNIT_LAT-1].vertex2_y;

    // Each corner meets its incoming edge (previous index) and outgoing edge.
    for (genvar g = 0; g < 3; g++) begin : g_corner
        teo_corner u_corner (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_u1x  (w_ux[(g + 2) % 3]),
            .i_u1y  (w_uy[(g + 2) % 3]),
            .i_u2x  (w_ux[g]),
            .i_u2y  (w_uy[g]),
            .i_s    (r_dl[UNIT_LAT-1].offset_distance),
            .i_px   (w_px[g]),
            .i_py   (w_py[g]),
            .o_cx   (w_cx[g]),
            .o_cy   (w_cy[g]),
            .o_flag (w_fl[g])
        );
    end

    // Output register; parallel edges take priority over saturation.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.corner0_x <= w_cx[0];
            r_out.corner0_y <= w_cy[0];
            r_out.corner1_x <= w_cx[1];
            r_out.corner1_y <= w_cy[1];
            r_out.corner2_x <= w_cx[2];
            r_out.corner2_y <= w_cy[2];
            if (w_fl[0].par || w_fl[1].par || w_fl[2].par) begin
                r_out.status <= STAT_PAR;
            end else if (w_fl[0].sat || w_fl[1].sat || w_fl[2].sat) begin
                r_out.status <= STAT_SAT;
            end else begin
                r_out.status <= STAT_OK;
            end
        end
    end

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.data.status == STAT_OK || o_out.data.status == STAT_PAR
                         || o_out.data.status == STAT_SAT))
        else $error("status code outside the defined set");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result shown right after reset");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_vld[PIPE_N-1] && (!o_out.valid || o_out.ready)) |=> !o_out.valid)
        else $error("result appeared without an item at the pipe end");

endmodule

`default_nettype wire

// ===== tb/teo_tb_if.sv =====
// Notes on the channel interfaces used by the triangle edge offset testbench.
`timescale 1ns / 1ps
// The testbench instantiates the block's own channel interfaces from rtl/core/teo_if.sv.
// They are not redefined here, so this file declares nothing.

// ===== tb/triangle_edge_offset_top_tb.sv =====
// Self-checking testbench for the triangle edge offset block with its own corner predictor.
`timescale 1ns / 1ps

module triangle_edge_offset_top_tb;
    import teo_pkg::*;

    localparam int UB = 30;

    logic i_clk;
    logic i_rst_n;

    teo_in_if  tri_ch ();
    teo_out_if cor_ch ();

    triangle_edge_offset_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tri_ch.sink),
        .o_out   (cor_ch.source)
    );

    // The clock runs at a 2 ns period.
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    t_teo_in  pending_tris[$];
    t_teo_out expected_corners[$];
    int       mismatch_count;
    bit       hold_off;

    // Integer square root of a value below 2^62.
    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Unit direction of an edge delta in Q2.30, (0,0) for a zero-length edge.
    function automatic void edge_direction(input longint dx, input longint dy,
                                           output longint ux, output longint uy);
        longint unsigned a, b, m, len, qa, qb;
        int k;
        a = dx < 0 ? -dx : dx;
        b = dy < 0 ? -dy : dy;
        m = a > b ? a : b;
        k = 0;
        while ((m >> k) >= (64'd1 << UB)) k++;
        a >>= k;
        b >>= k;
        len = root_floor(a * a + b * b);
        if (len == 0) begin
            ux = 0;
            uy = 0;
        end else begin
            qa = ((a << UB) + len / 2) / len;
            qb = ((b << UB) + len / 2) / len;
            ux = dx < 0 ? -longint'(qa) : longint'(qa);
            uy = dy < 0 ? -longint'(qb) : longint'(qb);
        end
    endfunction

    // Shift along one axis: round(s * e * 2^30 / c) on magnitudes, clamped to 2^32.
    function automatic longint axis_shift(longint s, longint e, longint c);
        logic [127:0] num;
        logic [127:0] quo;
        logic [127:0] dv;
        logic [127:0] lim;
        bit neg;
        dv  = c < 0 ? -c : c;
        num = 128'(s < 0 ? -s : s) * 128'(e < 0 ? -e : e);
        num = (num << UB) + (dv >> 1);
        quo = num / dv;
        lim = 128'd1 << COORD_W;
        if (quo > lim) quo = lim;
        neg = ((s < 0) != (e < 0)) != (c < 0);
        return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
    endfunction

    // Expected corners and status for one triangle.
    function automatic t_teo_out offset_corners(t_teo_in t);
        longint px[3], py[3], ux[3], uy[3];
        longint s, cr, v, hi, lo, sx, sy;
        bit par, sat;
        int a, b;
        logic [COORD_W-1:0] cx[3], cy[3];
        t_teo_out r;
        px[0] = t.vertex0_x; py[0] = t.vertex0_y;
        px[1] = t.vertex1_x; py[1] = t.vertex1_y;
        px[2] = t.vertex2_x; py[2] = t.vertex2_y;
        s   = t.offset_distance;
        hi  = 64'sd2147483647;
        lo  = -hi - 1;
        par = 0;
        sat = 0;
        for (int i = 0; i < 3; i++)
            edge_direction(px[(i + 1) % 3] - px[i], py[(i + 1) % 3] - py[i], ux[i], uy[i]);
        for (int i = 0; i < 3; i++) begin
            a  = (i + 2) % 3;
            b  = i;
            cr = ux[a] * uy[b] - uy[a] * ux[b];
            sx = px[i];
            sy = py[i];
            if (cr == 0) begin
                par = 1;
            end else begin
                v = sx + axis_shift(s, ux[a] - ux[b], cr);
                if (v > hi) begin v = hi; sat = 1; end
                if (v < lo) begin v = lo; sat = 1; end
                sx = v;
                v = sy + axis_shift(s, uy[a] - uy[b], cr);
                if (v > hi) begin v = hi; sat = 1; end
                if (v < lo) begin v = lo; sat = 1; end
                sy = v;
            end
            cx[i] = sx[COORD_W-1:0];
            cy[i] = sy[COORD_W-1:0];
        end
        r.corner0_x = cx[0]; r.corner0_y = cy[0];
        r.corner1_x = cx[1]; r.corner1_y = cy[1];
        r.corner2_x = cx[2]; r.corner2_y = cy[2];
        r.status = par ? STAT_PAR : (sat ? STAT_SAT : STAT_OK);
        return r;
    endfunction

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 400000)) - 200000);
            2: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
            default: return $urandom_range(0, 1) ? 32'h7fff_fff0 + $urandom_range(0, 15)
                                                 : 32'h8000_0000 + $urandom_range(0, 15);
        endcase
    endfunction

    task automatic add_tri(logic [31:0] x0, logic [31:0] y0, logic [31:0] x1,
                           logic [31:0] y1, logic [31:0] x2, logic [31:0] y2,
                           logic [31:0] d);
        t_teo_in t;
        t = '{x0, y0, x1, y1, x2, y2, d};
        pending_tris.insert(pending_tris.size(), t);
    endtask

    // Driver: bursts of items with random gaps; new data changes on the falling edge.
    int burst_left;
    int gap_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            tri_ch.valid <= 1'b0;
        end else if (tri_ch.valid && !tri_ch.ready) begin
            // Hold the offered item until the block takes it.
        end else if (gap_left > 0) begin
            gap_left--;
            tri_ch.valid <= 1'b0;
        end else if (pending_tris.size() > 0) begin
            tri_ch.data  <= pending_tris.pop_front();
            tri_ch.valid <= 1'b1;
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 40);
                gap_left   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
            end
        end else begin
            tri_ch.valid <= 1'b0;
        end
    end

    // The predictor runs when the block accepts an item.
    always @(posedge i_clk) begin
        if (i_rst_n && tri_ch.valid && tri_ch.ready)
            expected_corners.insert(expected_corners.size(), offset_corners(tri_ch.data));
    end

    // Receiver stall pattern, with one long hold-off while the sender keeps going.
    int rx_phase;
    always @(negedge i_clk) begin
        rx_phase++;
        if (!i_rst_n)
            cor_ch.ready <= 1'b0;
        else if (hold_off)
            cor_ch.ready <= 1'b0;
        else if (rx_phase % 700 < 150)
            cor_ch.ready <= 1'b1;
        else
            cor_ch.ready <= $urandom_range(0, 3) != 0;
    end

    initial begin
        hold_off = 0;
        wait (i_rst_n);
        repeat (300) @(posedge i_clk);
        hold_off = 1;
        repeat (400) @(posedge i_clk);
        hold_off = 0;
    end

    // Monitor: compare each taken result with the oldest expectation.
    always @(posedge i_clk) begin
        t_teo_out want;
        if (i_rst_n && cor_ch.valid && cor_ch.ready) begin
            if (expected_corners.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h", cor_ch.data);
            end else begin
                want = expected_corners.pop_front();
                if (want !== cor_ch.data) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: c0 %h,%h/%h,%h c1 %h,%h/%h,%h c2 %h,%h/%h,%h st %0d/%0d",
                                 want.corner0_x, want.corner0_y, cor_ch.data.corner0_x,
                                 cor_ch.data.corner0_y, want.corner1_x, want.corner1_y,
                                 cor_ch.data.corner1_x, cor_ch.data.corner1_y,
                                 want.corner2_x, want.corner2_y, cor_ch.data.corner2_x,
                                 cor_ch.data.corner2_y, want.status, cor_ch.data.status);
                end
            end
        end
    end

    initial begin
        int mode;
        logic [31:0] d;
        tri_ch.valid   = 1'b0;
        tri_ch.data    = '0;
        cor_ch.ready   = 1'b0;
        i_rst_n        = 1'b0;
        mismatch_count = 0;
        burst_left     = 0;
        gap_left       = 0;
        rx_phase       = 0;

        // Directed: plain triangle both ways round, both offset signs, degenerate cases.
        add_tri(32'h0, 32'h0, 32'h000a_0000, 32'h0, 32'h0, 32'h000a_0000, 32'h0001_0000);
        add_tri(32'h0, 32'h0, 32'h0, 32'h000a_0000, 32'h000a_0000, 32'h0, 32'h0001_0000);
        add_tri(32'h0, 32'h0, 32'h000a_0000, 32'h0, 32'h0, 32'h000a_0000, 32'hffff_0000);
        add_tri(32'h0, 32'h0, 32'h000a_0000, 32'h0, 32'h0, 32'h000a_0000, 32'h0);
        // A zero-length edge and a fully collapsed triangle.
        add_tri(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000,
                32'h0005_0000, 32'h0, 32'h0001_0000);
        add_tri(32'h1234, 32'h5678, 32'h1234, 32'h5678, 32'h1234, 32'h5678, 32'h7fff_ffff);
        // Collinear vertices make adjacent edges parallel.
        add_tri(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0002_0000,
                32'h0001_0000);
        // Extremes of the coordinate range and the offset, driving saturation.
        add_tri(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        add_tri(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        add_tri(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
        // A very thin sliver gives a tiny cross product and large shifts.
        add_tri(32'h0, 32'h0, 32'h0100_0000, 32'h1, 32'h0200_0000, 32'h0, 32'h0001_0000);
        add_tri(32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h1, 32'h1);
        add_tri(32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'hffff_ffff, 32'hffff_ffff, 32'h0,
                32'h8000_0000);

        for (int n = 0; n < 1350; n++) begin
            mode = $urandom_range(0, 9);
            d = $urandom_range(0, 3) == 0 ? $urandom
                                          : 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
            if (mode < 3)
                add_tri(rand_coord(1), rand_coord(1), rand_coord(1), rand_coord(1),
                        rand_coord(1), rand_coord(1), d);
            else if (mode < 6)
                add_tri(rand_coord(2), rand_coord(2), rand_coord(2), rand_coord(2),
                        rand_coord(2), rand_coord(2), d);
            else if (mode < 8)
                add_tri(rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0),
                        rand_coord(0), rand_coord(0), $urandom);
            else
                add_tri(rand_coord(3), rand_coord(0), rand_coord(3), rand_coord(3),
                        rand_coord(0), rand_coord(3), $urandom);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_tris.size() == 0);
        @(posedge i_clk);
        while (tri_ch.valid) @(posedge i_clk);
        wait (expected_corners.size() == 0);
        // Let the pipe drain, with a margin for strays.
        repeat (PIPE_N + 20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_corners.size() == 0)
            $display("triangle_edge_offset_top verification clean");
        else
            $display("triangle_edge_offset_top verification failed");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #400000;
        $display("triangle_edge_offset_top verification failed");
        $finish;
    end

endmodule
